@@ hw/rtl/twfd_pkg.sv @@
// shared types and constants for the typed word frame deframer
package twfd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned CFG_ADDR_W = 2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_START_ONE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_START_TWO = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CLOSING   = 2'd2;

	// register reset values
	localparam logic [BYTE_W-1:0] START_ONE_RST = 8'h5A;
	localparam logic [BYTE_W-1:0] START_TWO_RST = 8'h7A;
	localparam logic [BYTE_W-1:0] CLOSING_RST   = 8'h00;

	// current register contents seen by the frame logic
	typedef struct packed {
		logic [BYTE_W-1:0] start_one;
		logic [BYTE_W-1:0] start_two;
		logic [BYTE_W-1:0] closing;
	} cfg_t;

	// one finished record
	typedef struct packed {
		logic              valid;
		logic              record_type;
		logic [WORD_W-1:0] sample_number;
		logic [WORD_W-1:0] payload_word;
	} result_t;

endpackage

@@ hw/rtl/twfd_if.sv @@
// channel interfaces: received bytes, finished records, register writes

interface twfd_byte_if;
	import twfd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface twfd_rec_if;
	import twfd_pkg::*;
	logic              valid;
	logic              ready;
	logic              record_type;
	logic [WORD_W-1:0] sample_number;
	logic [WORD_W-1:0] payload_word;
	modport source (output valid, output record_type, output sample_number,
		output payload_word, input ready);
	modport sink (input valid, input record_type, input sample_number,
		input payload_word, output ready);
endinterface

interface twfd_cfg_if;
	import twfd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [BYTE_W-1:0]     data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/twfd_cfg_regs.sv @@
// configuration register file: start bytes and closing byte
module twfd_cfg_regs
	import twfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	twfd_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register update, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_one <= START_ONE_RST;
			regs_q.start_two <= START_TWO_RST;
			regs_q.closing   <= CLOSING_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_START_ONE: regs_q.start_one <= cfg.data;
				REG_START_TWO: regs_q.start_two <= cfg.data;
				REG_CLOSING:   regs_q.closing   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/twfd_core.sv @@
// frame state machine, payload shifter and per-type sample counters
module twfd_core
	import twfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              regs,
	output result_t           res
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_CLOSE   = 2'd2;
	localparam logic [2:0] POS_FIRST  = 3'd1;
	localparam logic [2:0] POS_FULL   = 3'd5;

	logic [1:0]        phase_q, phase_d;
	logic [2:0]        pos_q, pos_d;
	logic              type_two_q, type_two_d;
	logic [WORD_W-1:0] shift_q, shift_d;
	logic [WORD_W-1:0] cnt_one_q, cnt_one_d;
	logic [WORD_W-1:0] cnt_two_q, cnt_two_d;

	// next state and result for the byte at hand
	always_comb begin
		phase_d           = phase_q;
		pos_d             = pos_q;
		type_two_d        = type_two_q;
		shift_d           = shift_q;
		cnt_one_d         = cnt_one_q;
		cnt_two_d         = cnt_two_q;
		res.valid         = 1'b0;
		res.record_type   = type_two_q;
		res.sample_number = type_two_q ? cnt_two_q : cnt_one_q;
		res.payload_word  = shift_q;
		case (phase_q)
			PH_PAYLOAD: begin
				shift_d = {shift_q[WORD_W-BYTE_W-1:0], rx_byte};
				pos_d   = pos_q + 3'd1;
				if (pos_d >= POS_FULL) begin
					phase_d = PH_CLOSE;
				end
			end
			PH_CLOSE: begin
				// good close emits, a bad one just drops the frame
				if (rx_byte == regs.closing) begin
					res.valid = 1'b1;
					if (type_two_q) begin
						cnt_two_d = cnt_two_q + 1'b1;
					end else begin
						cnt_one_d = cnt_one_q + 1'b1;
					end
				end
				phase_d = PH_HUNT;
			end
			default: begin
				// hunting; type one wins when both start bytes match
				phase_d = PH_HUNT;
				if (rx_byte == regs.start_one || rx_byte == regs.start_two) begin
					type_two_d = (rx_byte != regs.start_one);
					shift_d    = '0;
					pos_d      = POS_FIRST;
					phase_d    = PH_PAYLOAD;
				end
			end
		endcase
	end

	// state registers advance once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			pos_q      <= POS_FIRST;
			type_two_q <= 1'b0;
			shift_q    <= '0;
			cnt_one_q  <= '0;
			cnt_two_q  <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			type_two_q <= type_two_d;
			shift_q    <= shift_d;
			cnt_one_q  <= cnt_one_d;
			cnt_two_q  <= cnt_two_d;
		end
	end

endmodule

@@ hw/rtl/twfd_out_reg.sv @@
// result register driving the record channel
module twfd_out_reg
	import twfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       free,
	twfd_rec_if.source rec
);

	logic              valid_q;
	logic              type_q;
	logic [WORD_W-1:0] number_q;
	logic [WORD_W-1:0] word_q;

	// room for a new result when empty or being drained this cycle
	assign free              = !valid_q || rec.ready;
	assign rec.valid         = valid_q;
	assign rec.record_type   = type_q;
	assign rec.sample_number = number_q;
	assign rec.payload_word  = word_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (rec.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			type_q   <= res.record_type;
			number_q <= res.sample_number;
			word_q   <= res.payload_word;
		end
	end

endmodule

@@ hw/rtl/typed_word_frame_deframer.sv @@
// top level of the typed word frame deframer
//
// Bytes from a serial receiver enter on the rx channel, one beat per byte.
// The block hunts for either configured start byte, collects four payload
// bytes (first byte most significant) and checks the closing byte. A good
// close puts one beat on the rec channel: record type, that type's sample
// number (count of earlier good records, wrapping at 2^32) and the word.
// Bad closes and stray bytes produce nothing.
// The cfg channel writes the start bytes and closing byte at any time it is
// valid; it is always ready and should only be used while the block is idle.
// A byte accepted on rx waits in the input register until the result register
// has room; a finished record is driven on rec from the result register.
// Throughput: one byte per cycle while rec takes records, set by the single
// input register feeding the frame logic and the result register.
// Reset clears the frame state, both sample counters and both pipeline
// registers, and loads the register defaults (0x5A, 0x7A, 0x00).
// When rec stalls with a record held, the input register keeps one byte
// and then rx ready drops until the record is taken.
module typed_word_frame_deframer
	import twfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	twfd_byte_if.sink  rx,
	twfd_rec_if.source rec,
	twfd_cfg_if.sink   cfg
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;
	cfg_t              regs;
	result_t           res;

	// the byte in the input register moves on when the result stage has room
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	twfd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	twfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.regs    (regs),
		.res     (res)
	);

	twfd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res    (res),
		.free   (out_free),
		.rec    (rec)
	);

endmodule

@@ bench/typed_word_frame_deframer_tb.sv @@
// self-checking testbench for the typed word frame deframer: byte streams in, records checked
`timescale 1ns / 100ps

module typed_word_frame_deframer_tb;
	import twfd_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE    = 4;
	localparam int PHASE_LEN = 170;

	typedef enum logic [1:0] {PH_HUNT, PH_PAYLOAD, PH_CLOSE} frame_phase_e;

	typedef struct packed {
		logic              record_type;
		logic [WORD_W-1:0] sample_number;
		logic [WORD_W-1:0] payload_word;
	} record_t;

	// frame predictor plus the queue of records still to come out
	class record_scoreboard;
		logic [BYTE_W-1:0] start_one, start_two, closing;
		frame_phase_e      fphase;
		logic [2:0]        position;
		logic              is_two;
		logic [WORD_W-1:0] shift_word, count_one, count_two;
		record_t           awaited[$];
		int                errors;

		function new();
			start_one  = START_ONE_RST;
			start_two  = START_TWO_RST;
			closing    = CLOSING_RST;
			fphase     = PH_HUNT;
			position   = 3'd1;
			is_two     = 1'b0;
			shift_word = '0;
			count_one  = '0;
			count_two  = '0;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [BYTE_W-1:0] val);
			case (idx)
				REG_START_ONE: start_one = val;
				REG_START_TWO: start_two = val;
				REG_CLOSING:   closing = val;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		// one accepted rx beat through the frame state
		function void note_byte(logic [BYTE_W-1:0] b);
			record_t rec;
			case (fphase)
				PH_PAYLOAD: begin
					shift_word = {shift_word[WORD_W-BYTE_W-1:0], b};
					position   = position + 3'd1;
					if (position >= 3'd5)
						fphase = PH_CLOSE;
				end
				PH_CLOSE: begin
					if (b == closing) begin
						rec.record_type  = is_two;
						rec.payload_word = shift_word;
						if (is_two) begin
							rec.sample_number = count_two;
							count_two = count_two + 1;
						end else begin
							rec.sample_number = count_one;
							count_one = count_one + 1;
						end
						awaited.push_back(rec);
					end
					fphase = PH_HUNT;
				end
				default: begin
					// a byte matching both start bytes opens a type one frame
					fphase = PH_HUNT;
					if (b == start_one || b == start_two) begin
						is_two     = (b != start_one);
						shift_word = '0;
						position   = 3'd1;
						fphase     = PH_PAYLOAD;
					end
				end
			endcase
		endfunction

		task report(string msg);
			// keep the log short when the block is badly off
			if (errors < 60)
				$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_record(record_t got);
			record_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected record type=%0d num=%0d word=%h",
					got.record_type, got.sample_number, got.payload_word));
			end else begin
				want = awaited.pop_front();
				if (got.record_type !== want.record_type)
					report($sformatf("record_type got %0d want %0d",
						got.record_type, want.record_type));
				if (got.sample_number !== want.sample_number)
					report($sformatf("sample_number got %0d want %0d",
						got.sample_number, want.sample_number));
				if (got.payload_word !== want.payload_word)
					report($sformatf("payload_word got %h want %h",
						got.payload_word, want.payload_word));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_req;

	record_scoreboard sb = new();
	record_t          seen_rec;

	twfd_byte_if rx_ch ();
	twfd_rec_if  rec_ch ();
	twfd_cfg_if  cfg_ch ();

	typed_word_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.rec(rec_ch),
		.cfg(cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one; none in calm stretches
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// bytes biased toward the values the frame logic compares against
	function automatic logic [BYTE_W-1:0] spice_byte(input logic [BYTE_W-1:0] s1, s2, cl);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'h00;
		if (r < 20)
			return 8'hFF;
		if (r < 30)
			return cl;
		if (r < 40)
			return $urandom_range(0, 1) ? s1 : s2;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// watch every channel and feed the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_ch.valid && rec_ch.ready) begin
				seen_rec.record_type   = rec_ch.record_type;
				seen_rec.sample_number = rec_ch.sample_number;
				seen_rec.payload_word  = rec_ch.payload_word;
				sb.check_record(seen_rec);
			end
			if (rx_ch.valid && rx_ch.ready)
				sb.note_byte(rx_ch.rx_byte);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.addr, cfg_ch.data);
		end
	end

	// record sink: random stalls, plus one long hold-off on request
	initial begin : rec_sink
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				rec_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = idle_len();
				if (gap != 0) begin
					rec_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				rec_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// one rx beat, after a random gap
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
	endtask

	// stop sending until every record is out and the pipeline is empty
	task automatic drain_records();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register writes, back to back, only while the block is idle
	task automatic program_regs(input logic [BYTE_W-1:0] s1, s2, cl, input bit poke);
		logic [CFG_ADDR_W-1:0] idx[$];
		logic [BYTE_W-1:0]     val[$];
		idx = '{REG_START_ONE, REG_START_TWO, REG_CLOSING};
		val = '{s1, s2, cl};
		if (poke) begin
			idx.push_back(REG_UNUSED);
			val.push_back(BYTE_W'($urandom_range(0, 255)));
		end
		foreach (idx[i]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.addr  <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// one register setting followed by random frames; may stop mid-frame
	task automatic run_phase(input logic [BYTE_W-1:0] s1, s2, cl, input bit poke,
		input int quota, input bit quiet, input bit squeeze);
		logic [BYTE_W-1:0] frame[$];
		int                sent;
		program_regs(s1, s2, cl, poke);
		calm = quiet;
		if (squeeze)
			hold_req = 1'b1;
		sent = 0;
		while (sent < quota) begin
			frame.delete();
			if ($urandom_range(0, 99) < 15) begin
				frame.push_back(spice_byte(s1, s2, cl));
			end else begin
				frame.push_back($urandom_range(0, 1) ? s1 : s2);
				repeat (4) frame.push_back(spice_byte(s1, s2, cl));
				frame.push_back($urandom_range(0, 99) < 85 ? cl : spice_byte(s1, s2, cl));
			end
			foreach (frame[k]) begin
				if (sent < quota) begin
					send_byte(frame[k]);
					sent++;
				end
			end
			if ($urandom_range(0, 39) == 0)
				drain_records();
		end
		calm = 1'b0;
		drain_records();
	endtask

	initial begin
		logic [BYTE_W-1:0] warmup[$];
		arst_n         = 1'b0;
		calm           = 1'b0;
		hold_req       = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.addr    = '0;
		cfg_ch.data    = '0;
		rec_ch.ready   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: stray byte, all-ones and all-zero words, a wrong close
		// that is itself a start byte, then a frame right behind it
		warmup = '{8'h33,
			8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
			8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h5A, 8'h12, 8'h34, 8'h56, 8'h78, 8'h5A,
			8'h7A, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00};
		foreach (warmup[i])
			send_byte(warmup[i]);
		drain_records();

		run_phase(START_ONE_RST, START_TWO_RST, CLOSING_RST, 1'b1, PHASE_LEN + 10, 1'b0, 1'b0);
		// receiver holds off while the sender keeps offering
		run_phase(8'h00, 8'hFF, 8'hFF, 1'b0, PHASE_LEN, 1'b0, 1'b1);
		run_phase(8'hFF, 8'h00, 8'h00, 1'b1, PHASE_LEN, 1'b1, 1'b0);
		// equal start bytes
		run_phase(8'hC3, 8'hC3, 8'h3C, 1'b0, PHASE_LEN, 1'b0, 1'b0);
		// closing byte equal to a start byte, back-to-back sender under a hold-off
		run_phase(8'h41, 8'h42, 8'h41, 1'b0, PHASE_LEN, 1'b1, 1'b1);
		repeat (5)
			run_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
				BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				PHASE_LEN, 1'b0, 1'b0);

		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d records never came out", sb.outstanding()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/twfd_pkg.sv
hw/rtl/twfd_if.sv
hw/rtl/twfd_cfg_regs.sv
hw/rtl/twfd_core.sv
hw/rtl/twfd_out_reg.sv
hw/rtl/typed_word_frame_deframer.sv
bench/typed_word_frame_deframer_tb.sv
